@@ src/vhd_read_translate_top_assert.svh @@
// ----------------------------------------------------------------------------
// vhd_read_translate_top_assert.svh
// assertion macros shared by the read translator modules
// ----------------------------------------------------------------------------
`ifndef VHD_READ_TRANSLATE_TOP_ASSERT_SVH
`define VHD_READ_TRANSLATE_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define VRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define VRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/vrt_pkg.sv @@
// ----------------------------------------------------------------------------
// vrt_pkg
// shared codes, widths, control structs and helpers of the read translator
// ----------------------------------------------------------------------------
package vrt_pkg;

  // storage geometry
  localparam int TABLE_DEPTH  = 4096;
  localparam int TABLE_AW     = 12;
  localparam int BITMAP_WORDS = 64;
  localparam int BITMAP_AW    = 6;

  localparam logic [31:0] UNALLOCATED = 32'hFFFF_FFFF;

  // block shift clamp range
  localparam logic [4:0] SHIFT_MIN = 5'd18;
  localparam logic [4:0] SHIFT_MAX = 5'd21;

  // operations
  localparam logic [1:0] OP_LOAD_TABLE  = 2'd0;
  localparam logic [1:0] OP_LOAD_BITMAP = 2'd1;
  localparam logic [1:0] OP_TRANSLATE   = 2'd2;

  // result status
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BEYOND_DISK  = 2'd1;
  localparam logic [1:0] ST_BEYOND_TABLE = 2'd2;

  // result source
  localparam logic [1:0] SRC_ZERO   = 2'd0;
  localparam logic [1:0] SRC_PARENT = 2'd1;
  localparam logic [1:0] SRC_FILE   = 2'd2;

  // configuration registers
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 42;
  localparam logic [2:0] REG_DISK_SIZE      = 3'd0;
  localparam logic [2:0] REG_BLOCK_SHIFT    = 3'd1;
  localparam logic [2:0] REG_TABLE_ENTRIES  = 3'd2;
  localparam logic [2:0] REG_BITMAP_SECTORS = 3'd3;
  localparam logic [2:0] REG_HAS_PARENT     = 3'd4;
  localparam logic [2:0] REG_FIXED_DISK     = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic check;
    logic lookup;
    logic scan;
    logic finish;
    logic publish;
  } vrt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;
    logic fixed;
    logic unalloc;
    logic scan_done;
  } vrt_stat_t;

  // position of the first set bit counted from the msb
  function automatic logic [5:0] lead_zeros(input logic [63:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 6'(63 - i);
    end
    return n;
  endfunction

endpackage

@@ src/vrt_ram.sv @@
// ----------------------------------------------------------------------------
// vrt_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module vrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ src/vrt_datapath.sv @@
// ----------------------------------------------------------------------------
// vrt_datapath
// config registers, table and bitmap memories, bounds checks, run scan
// ----------------------------------------------------------------------------
`include "vhd_read_translate_top_assert.svh"

module vrt_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [vrt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [vrt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                       operation,
  input  logic [11:0]                      slot,
  input  logic [63:0]                      load_value,
  input  logic [41:0]                      byte_offset,
  input  logic [31:0]                      request_length,
  input  vrt_pkg::vrt_cmd_t                cmd,
  output vrt_pkg::vrt_stat_t               stat,
  output logic [1:0]                       status,
  output logic [1:0]                       source,
  output logic [41:0]                      file_offset,
  output logic [31:0]                      run_length
);

  // configuration
  logic [41:0] disk_size;
  logic [4:0]  block_shift;
  logic [12:0] table_entries;
  logic        bitmap_sectors;
  logic        has_parent;
  logic        fixed_disk;

  // captured item
  logic [1:0]  op_q;
  logic [11:0] slot_q;
  logic [63:0] value_q;
  logic [41:0] off_q;
  logic [31:0] len_q;

  // per translate state
  logic [11:0] sector_q;
  logic [8:0]  in_sec_q;
  logic [21:0] len_clip_q;
  logic [5:0]  last_word_q;
  logic [5:0]  scan_word;
  logic        first;
  logic        data_q;
  logic [12:0] end_q;
  logic [41:0] fo_q;

  // pending result
  logic [1:0]  res_status;
  logic [1:0]  res_source;
  logic [41:0] res_offset;
  logic [31:0] res_len;

  // memories
  logic [31:0] tbl_rdata;
  logic [63:0] bm_rdata;
  logic        tbl_we;
  logic        bm_we;
  logic [5:0]  bm_raddr;

  // combinational
  logic [1:0]  shift_sel;
  logic [23:0] blk;
  logic [20:0] in_block;
  logic [21:0] block_bytes;
  logic [21:0] remain;
  logic [21:0] len_clip_c;
  logic [5:0]  last_word_c;
  logic        bound_err;
  logic        tbl_err;
  logic [1:0]  parent_src;
  logic [32:0] fo_sum;
  logic        data_cur;
  logic [63:0] mask;
  logic [63:0] diff;
  logic        hit;
  logic        at_last;
  logic [12:0] end_c;
  logic [12:0] run_sectors;
  logic [21:0] run_full;
  logic [21:0] run_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_size      <= 42'd0;
      block_shift    <= 5'd21;
      table_entries  <= 13'd1;
      bitmap_sectors <= 1'b1;
      has_parent     <= 1'b0;
      fixed_disk     <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vrt_pkg::REG_DISK_SIZE:      disk_size      <= cfg_data;
        vrt_pkg::REG_BLOCK_SHIFT:    block_shift    <= cfg_data[4:0];
        vrt_pkg::REG_TABLE_ENTRIES:  table_entries  <= cfg_data[12:0];
        vrt_pkg::REG_BITMAP_SECTORS: bitmap_sectors <= cfg_data[0];
        vrt_pkg::REG_HAS_PARENT:     has_parent     <= cfg_data[0];
        vrt_pkg::REG_FIXED_DISK:     fixed_disk     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // block geometry from the clamped shift
  always_comb begin
    if (block_shift < vrt_pkg::SHIFT_MIN) begin
      shift_sel = 2'd0;
    end else if (block_shift > vrt_pkg::SHIFT_MAX) begin
      shift_sel = 2'd3;
    end else begin
      shift_sel = 2'(block_shift - vrt_pkg::SHIFT_MIN);
    end
  end

  always_comb begin
    case (shift_sel)
      2'd0: begin
        blk         = off_q[41:18];
        in_block    = {3'b0, off_q[17:0]};
        last_word_c = 6'd7;
      end
      2'd1: begin
        blk         = {1'b0, off_q[41:19]};
        in_block    = {2'b0, off_q[18:0]};
        last_word_c = 6'd15;
      end
      2'd2: begin
        blk         = {2'b0, off_q[41:20]};
        in_block    = {1'b0, off_q[19:0]};
        last_word_c = 6'd31;
      end
      default: begin
        blk         = {3'b0, off_q[41:21]};
        in_block    = off_q[20:0];
        last_word_c = 6'd63;
      end
    endcase
  end

  assign block_bytes = 22'd1 << (5'd18 + {3'b0, shift_sel});
  assign remain      = block_bytes - {1'b0, in_block};
  assign len_clip_c  = ({10'b0, remain} < len_q) ? remain : len_q[21:0];
  assign bound_err   = ({1'b0, off_q} + {11'b0, len_q}) > {1'b0, disk_size};
  assign tbl_err     = (blk >= {11'b0, table_entries}) || (blk[23:12] != 12'd0);
  assign parent_src  = has_parent ? vrt_pkg::SRC_PARENT : vrt_pkg::SRC_ZERO;
  assign fo_sum      = {1'b0, tbl_rdata} + {32'b0, bitmap_sectors} + {21'b0, sector_q};

  // one bitmap word per scan cycle, msb is the lowest sector
  assign data_cur = first ? bm_rdata[~sector_q[5:0]] : data_q;
  assign mask     = first ? (~64'd0 >> sector_q[5:0]) : ~64'd0;
  assign diff     = (bm_rdata ^ {64{data_cur}}) & mask;
  assign hit      = |diff;
  assign at_last  = scan_word == last_word_q;
  assign end_c    = hit ? {1'b0, scan_word, vrt_pkg::lead_zeros(diff)}
                        : {({1'b0, last_word_q} + 7'd1), 6'd0};

  assign run_sectors = end_q - {1'b0, sector_q};
  assign run_full    = {run_sectors, 9'd0} - {13'b0, in_sec_q};
  assign run_final   = (run_full < len_clip_q) ? run_full : len_clip_q;

  assign stat.err       = bound_err || (!fixed_disk && tbl_err);
  assign stat.fixed     = fixed_disk;
  assign stat.unalloc   = tbl_rdata == vrt_pkg::UNALLOCATED;
  assign stat.scan_done = hit || at_last;

  // memories
  assign tbl_we   = cmd.load && (op_q == vrt_pkg::OP_LOAD_TABLE);
  assign bm_we    = cmd.load && (op_q == vrt_pkg::OP_LOAD_BITMAP) && (slot_q[11:6] == 6'd0);
  assign bm_raddr = cmd.scan ? scan_word + 6'd1 : scan_word;

  vrt_ram #(
    .WIDTH (32),
    .DEPTH (vrt_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (slot_q),
    .wdata (value_q[31:0]),
    .raddr (blk[vrt_pkg::TABLE_AW-1:0]),
    .rdata (tbl_rdata)
  );

  vrt_ram #(
    .WIDTH (64),
    .DEPTH (vrt_pkg::BITMAP_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (slot_q[vrt_pkg::BITMAP_AW-1:0]),
    .wdata (value_q),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= operation;
      slot_q  <= slot;
      value_q <= load_value;
      off_q   <= byte_offset;
      len_q   <= request_length;
    end

    if (cmd.check) begin
      sector_q    <= in_block[20:9];
      in_sec_q    <= off_q[8:0];
      len_clip_q  <= len_clip_c;
      last_word_q <= last_word_c;
      scan_word   <= in_block[20:15];
      first       <= 1'b1;
      if (bound_err) begin
        res_status <= vrt_pkg::ST_BEYOND_DISK;
        res_source <= vrt_pkg::SRC_ZERO;
        res_offset <= 42'd0;
        res_len    <= 32'd0;
      end else if (fixed_disk) begin
        res_status <= vrt_pkg::ST_OK;
        res_source <= vrt_pkg::SRC_FILE;
        res_offset <= off_q;
        res_len    <= len_q;
      end else begin
        res_status <= vrt_pkg::ST_BEYOND_TABLE;
        res_source <= vrt_pkg::SRC_ZERO;
        res_offset <= 42'd0;
        res_len    <= 32'd0;
      end
    end

    if (cmd.lookup) begin
      fo_q       <= {fo_sum, in_sec_q};
      res_status <= vrt_pkg::ST_OK;
      res_source <= parent_src;
      res_offset <= 42'd0;
      res_len    <= {10'b0, len_clip_q};
    end

    if (cmd.scan) begin
      first     <= 1'b0;
      data_q    <= data_cur;
      scan_word <= scan_word + 6'd1;
      if (hit || at_last) end_q <= end_c;
    end

    if (cmd.finish) begin
      res_status <= vrt_pkg::ST_OK;
      res_source <= data_q ? vrt_pkg::SRC_FILE : parent_src;
      res_offset <= data_q ? fo_q : 42'd0;
      res_len    <= {10'b0, run_final};
    end

    if (cmd.publish) begin
      status      <= res_status;
      source      <= res_source;
      file_offset <= res_offset;
      run_length  <= res_len;
    end
  end

  `VRT_ASSERT_NOW(a_run_nonempty, cmd.finish, (end_q > ({1'b0, sector_q})),
    "run ends at or before its first sector")
  `VRT_ASSERT_NOW(a_run_in_block, cmd.finish,
    (end_q <= ({({1'b0, last_word_q} + 7'd1), 6'd0})), "run passes the block end")
  `VRT_ASSERT_NEXT(a_len_clipped, cmd.finish, (res_len <= ({10'b0, len_clip_q})),
    "run length exceeds the clipped request")

endmodule

@@ src/vrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// vrt_ctrl
// sequencer for loads and translations, owns the result valid flag
// ----------------------------------------------------------------------------
`include "vhd_read_translate_top_assert.svh"

module vrt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  output logic               out_valid,
  input  logic               out_ready,
  input  vrt_pkg::vrt_stat_t stat,
  output vrt_pkg::vrt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_CHECK,
    S_LOOKUP,
    S_SCAN,
    S_FINISH,
    S_RESULT
  } state_t;

  state_t state;

  assign in_ready    = state == S_IDLE;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.load    = state == S_LOAD;
  assign cmd.check   = state == S_CHECK;
  assign cmd.lookup  = state == S_LOOKUP;
  assign cmd.scan    = state == S_SCAN;
  assign cmd.finish  = state == S_FINISH;
  assign cmd.publish = (state == S_RESULT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (operation) inside
              vrt_pkg::OP_LOAD_TABLE, vrt_pkg::OP_LOAD_BITMAP: state <= S_LOAD;
              vrt_pkg::OP_TRANSLATE: state <= S_CHECK;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: state <= S_IDLE;
        S_CHECK: begin
          if (stat.err || stat.fixed) state <= S_RESULT;
          else state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          if (stat.unalloc) state <= S_RESULT;
          else state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.scan_done) state <= S_FINISH;
        end
        S_FINISH: state <= S_RESULT;
        S_RESULT: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VRT_ASSERT_NEXT(a_translate_checks,
    (in_valid && in_ready && (operation == vrt_pkg::OP_TRANSLATE)), (state == S_CHECK),
    "translate not followed by a bounds check")
  `VRT_ASSERT_NEXT(a_result_waits, ((state == S_RESULT) && out_valid && !out_ready),
    (state == S_RESULT), "new result left its slot while the old one waits")
  `VRT_ASSERT_NEXT(a_busy_after_accept,
    (cmd.capture && ((operation == vrt_pkg::OP_LOAD_TABLE) ||
     (operation == vrt_pkg::OP_LOAD_BITMAP) || (operation == vrt_pkg::OP_TRANSLATE))),
    !in_ready, "second item taken right after an accept")

endmodule

@@ src/vhd_read_translate_top.sv @@
// ----------------------------------------------------------------------------
// vhd_read_translate_top
// read request translator for block allocated virtual disk images
// ----------------------------------------------------------------------------
// The block takes one item at a time. A table or bitmap load gives no
// result. A translate that fails a bound check, or one on a fixed image,
// goes from its check step to the result; one on an unallocated block goes
// from its table lookup to the result; one on an allocated block then scans
// 1 to 64 of the 64-bit bitmap words, one word per cycle through the bitmap
// memory's read port, before a finish step. The result sits in an output
// register; loads are still taken while it waits, and the next translate
// stalls in its last step until the result is taken. The table (4096 x 32)
// and the bitmap (64 x 64) are plain memories with no clearing pass; the
// host loads every entry it will use before translating.
// ----------------------------------------------------------------------------
module vhd_read_translate_top (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_write,
  input  logic [vrt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vrt_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input item
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      operation,
  input  logic [11:0]                     slot,
  input  logic [63:0]                     load_value,
  input  logic [41:0]                     byte_offset,
  input  logic [31:0]                     request_length,
  // result item
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [1:0]                      source,
  output logic [41:0]                     file_offset,
  output logic [31:0]                     run_length
);

  // command and status between sequencer and datapath
  vrt_pkg::vrt_cmd_t  cmd;
  vrt_pkg::vrt_stat_t stat;

  // sequencer: idle, load, check, lookup, scan, finish, result
  vrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: config regs, memories, checks, bitmap run scan, result regs
  vrt_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .slot           (slot),
    .load_value     (load_value),
    .byte_offset    (byte_offset),
    .request_length (request_length),
    .cmd            (cmd),
    .stat           (stat),
    .status         (status),
    .source         (source),
    .file_offset    (file_offset),
    .run_length     (run_length)
  );

endmodule
